// ----- sv/sdfp_pkg.sv -----
// shared types, constants and header field table for the discovery frame parser
// no dependencies; used by every module of the block
package sdfp_pkg;

	// stream widths
	localparam int IN_W    = 8;
	localparam int TDATA_W = 88;
	localparam int TUSER_W = 2;

	// header is 26 bytes, destination through checksum
	localparam logic [4:0] HDR_BYTES = 5'd26;

	// bytes of the length field not counted in the payload
	localparam logic [15:0] LEN_OVERHEAD = 16'd12;

	// smallest legal entry: type and length only
	localparam logic [15:0] ENTRY_HDR_LEN = 16'd4;

	// header field numbers
	localparam logic [3:0] FLD_DEST     = 4'd0;
	localparam logic [3:0] FLD_SOURCE   = 4'd1;
	localparam logic [3:0] FLD_LENGTH   = 4'd2;
	localparam logic [3:0] FLD_DSAP     = 4'd3;
	localparam logic [3:0] FLD_SSAP     = 4'd4;
	localparam logic [3:0] FLD_CONTROL  = 4'd5;
	localparam logic [3:0] FLD_OUI      = 4'd6;
	localparam logic [3:0] FLD_PROTO    = 4'd7;
	localparam logic [3:0] FLD_VERSION  = 4'd8;
	localparam logic [3:0] FLD_TTL      = 4'd9;
	localparam logic [3:0] FLD_CHECKSUM = 4'd10;
	localparam logic [3:0] NO_FIELD     = 4'd15;

	// error codes
	localparam logic [3:0] ERR_SHORT = 4'd0;
	localparam logic [3:0] ERR_TRUNC = 4'd1;

	// record kinds
	typedef enum logic [1:0] {
		KIND_HDR   = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_VALUE = 2'd2,
		KIND_ERR   = 2'd3
	} sdfp_kind_t;

	// parse phases
	typedef enum logic [1:0] {
		PH_HEADER    = 2'd0,
		PH_ENTRY_HDR = 2'd1,
		PH_ENTRY_VAL = 2'd2,
		PH_IGNORE    = 2'd3
	} sdfp_phase_t;

	// one result record
	typedef struct packed {
		sdfp_kind_t  kind;
		logic [3:0]  id;
		logic [47:0] value;
		logic [15:0] etype;
		logic [15:0] elen;
		logic        done;
	} sdfp_rec_t;

	// records handed from the parser to the output queue in one cycle
	typedef struct packed {
		logic [1:0] cnt;
		sdfp_rec_t  first;
		sdfp_rec_t  second;
	} sdfp_push_t;

	// field that completes at a given header byte, NO_FIELD elsewhere
	function automatic logic [3:0] hdr_field_at(input logic [4:0] pos);
		logic [3:0] id;
		unique case (pos)
			5'd5:    id = FLD_DEST;
			5'd11:   id = FLD_SOURCE;
			5'd13:   id = FLD_LENGTH;
			5'd14:   id = FLD_DSAP;
			5'd15:   id = FLD_SSAP;
			5'd16:   id = FLD_CONTROL;
			5'd19:   id = FLD_OUI;
			5'd21:   id = FLD_PROTO;
			5'd22:   id = FLD_VERSION;
			5'd23:   id = FLD_TTL;
			5'd25:   id = FLD_CHECKSUM;
			default: id = NO_FIELD;
		endcase
		return id;
	endfunction

endpackage

// ----- sv/snap_discovery_frame_parser.sv -----
// top level of the discovery frame parser: input stage, parser and result queue
// depends on sdfp_pkg, sdfp_parse and sdfp_outq
//
// Usage:
//   s_* channel takes the captured frame one byte per request, starting at the
//   destination address; s_tlast marks the last captured byte of the frame.
//   m_* channel gives result records: header fields, entry headers, entry value
//   bytes and error records. m_tuser is the record kind, m_tlast marks the
//   record that ends the parse of the frame.
// Throughput: one byte per cycle unless the queue lacks room. A byte gives at most
//   two records; only a frame that ends before its payload is done gives two.
//   With m_tready held high the queue always has room for the waiting byte,
//   so s_tready stays high.
// Record path: a taken byte is held in the input register, then its records
//   are written into the result queue, whose head drives m_*.
// Reset: arst_n clears the parse state, the input register and the queue;
//   the block then expects the first byte of a frame. The last byte of every
//   frame also returns the parse state to that point.
// Stall: while m_tready is low the queue holds its records; once the queue
//   cannot take the records of the waiting byte, s_tready falls.
module snap_discovery_frame_parser import sdfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,  // [7:0] data_byte
	input  logic               s_tlast,  // frame_end
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // [3:0] field_id, [51:4] field_value,
	                                     // [67:52] entry_type, [83:68] entry_length
	output logic [TUSER_W-1:0] m_tuser,  // [1:0] record_kind
	output logic               m_tlast   // frame_done
);

	sdfp_push_t push;
	logic [1:0] room;
	sdfp_rec_t  head;

	sdfp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.room     (room),
		.push     (push)
	);

	sdfp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (m_tvalid),
		.head_ready (m_tready),
		.head       (head)
	);

	// pack the head record onto the stream
	assign m_tdata = {4'd0, head.elen, head.etype, head.value, head.id};
	assign m_tuser = head.kind;
	assign m_tlast = head.done;

endmodule

// ----- sv/sdfp_parse.sv -----
// input register, parse state and per-byte record generation
// depends on sdfp_pkg; feeds sdfp_outq through an sdfp_push_t bundle
module sdfp_parse import sdfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [7:0] data_byte
	input  logic             s_tlast,   // frame_end
	input  logic [1:0]       room,
	output sdfp_push_t       push
);

	// input register
	logic             v_s1;
	logic [IN_W-1:0]  byte_s1;
	logic             last_s1;

	// parse state
	sdfp_phase_t phase_q;
	logic [4:0]  bpos_q;
	logic [47:0] acc_q;
	logic [15:0] length_q;
	logic [15:0] ppos_q;
	logic [15:0] type_q;
	logic [15:0] clen_q;
	logic [15:0] ebc_q;

	// next state
	sdfp_phase_t phase_step, phase_d;
	logic [4:0]  bpos_d;
	logic [47:0] acc_d;
	logic [15:0] length_d, ppos_d, type_step, clen_step, type_d, clen_d, ebc_d;

	// shared terms
	logic [47:0] acc_new;
	logic [3:0]  fid;
	logic [15:0] ppos_inc, ebc_inc, clen_new;
	logic        pay_done, short_payload;

	// records
	sdfp_rec_t rec_a, rec_b;
	logic      a_v, b_v;
	logic [1:0] n_rec;
	logic      go;

	// terms used by both next state and records
	always_comb begin
		acc_new       = {acc_q[39:0], byte_s1};
		fid           = hdr_field_at(bpos_q);
		ppos_inc      = (ppos_q == 16'hFFFF) ? ppos_q : ppos_q + 16'd1;
		ebc_inc       = ebc_q + 16'd1;
		clen_new      = {clen_q[7:0], byte_s1};
		pay_done      = ppos_inc >= (length_q - LEN_OVERHEAD);
		short_payload = length_q <= LEN_OVERHEAD;
	end

	// next state
	always_comb begin
		phase_step = phase_q;
		bpos_d     = bpos_q;
		acc_d      = acc_q;
		length_d   = length_q;
		ppos_d     = ppos_q;
		type_step  = type_q;
		clen_step  = clen_q;
		ebc_d      = ebc_q;
		unique case (phase_q)
			PH_HEADER: begin
				acc_d = acc_new;
				if (bpos_q != HDR_BYTES) begin
					bpos_d = bpos_q + 5'd1;
				end
				if (fid != NO_FIELD) begin
					acc_d = '0;
					if (fid == FLD_LENGTH) begin
						length_d = acc_new[15:0];
					end
					if (fid == FLD_CHECKSUM) begin
						if (short_payload) begin
							phase_step = PH_IGNORE;
						end else begin
							phase_step = PH_ENTRY_HDR;
							ppos_d     = '0;
							ebc_d      = '0;
						end
					end
				end
			end
			PH_ENTRY_HDR: begin
				ppos_d = ppos_inc;
				ebc_d  = ebc_inc;
				case (ebc_q)
					16'd0:   type_step = {8'd0, byte_s1};
					16'd1:   type_step = {type_q[7:0], byte_s1};
					16'd2:   clen_step = {8'd0, byte_s1};
					default: clen_step = clen_new;
				endcase
				if (ebc_q >= 16'd3) begin
					if (clen_new < ENTRY_HDR_LEN) begin
						phase_step = PH_IGNORE;
					end else if (clen_new == ENTRY_HDR_LEN) begin
						ebc_d      = '0;
						phase_step = pay_done ? PH_IGNORE : PH_ENTRY_HDR;
					end else begin
						phase_step = PH_ENTRY_VAL;
					end
				end
			end
			PH_ENTRY_VAL: begin
				ppos_d = ppos_inc;
				ebc_d  = ebc_inc;
				if (ebc_inc >= clen_q) begin
					ebc_d      = '0;
					phase_step = pay_done ? PH_IGNORE : PH_ENTRY_HDR;
				end
			end
			PH_IGNORE: begin
			end
			default: begin
			end
		endcase
		// frame end returns everything to the reset state
		phase_d = phase_step;
		type_d  = type_step;
		clen_d  = clen_step;
		if (last_s1) begin
			phase_d  = PH_HEADER;
			bpos_d   = '0;
			acc_d    = '0;
			length_d = '0;
			ppos_d   = '0;
			type_d   = '0;
			clen_d   = '0;
			ebc_d    = '0;
		end
	end

	// records for this byte
	always_comb begin
		rec_a = '0;
		a_v   = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (fid != NO_FIELD) begin
					a_v         = 1'b1;
					rec_a.kind  = KIND_HDR;
					rec_a.id    = fid;
					rec_a.value = acc_new;
					rec_a.done  = (fid == FLD_CHECKSUM) && short_payload;
				end
			end
			PH_ENTRY_HDR: begin
				if (ebc_q >= 16'd3) begin
					a_v         = 1'b1;
					rec_a.etype = type_q;
					rec_a.elen  = clen_new;
					if (clen_new < ENTRY_HDR_LEN) begin
						rec_a.kind = KIND_ERR;
						rec_a.id   = ERR_SHORT;
						rec_a.done = 1'b1;
					end else begin
						rec_a.kind = KIND_ENTRY;
						rec_a.done = (clen_new == ENTRY_HDR_LEN) && pay_done;
					end
				end
			end
			PH_ENTRY_VAL: begin
				a_v         = 1'b1;
				rec_a.kind  = KIND_VALUE;
				rec_a.value = {40'd0, byte_s1};
				rec_a.etype = type_q;
				rec_a.elen  = clen_q;
				rec_a.done  = (ebc_inc >= clen_q) && pay_done;
			end
			PH_IGNORE: begin
			end
			default: begin
			end
		endcase
		// truncated frame
		b_v        = last_s1 && (phase_step != PH_IGNORE);
		rec_b      = '0;
		rec_b.kind = KIND_ERR;
		rec_b.id   = ERR_TRUNC;
		rec_b.etype = type_step;
		rec_b.elen = clen_step;
		rec_b.done = 1'b1;
	end

	// hand-off to the queue when it has room for every record of this byte
	always_comb begin
		n_rec       = {1'b0, a_v} + {1'b0, b_v};
		go          = v_s1 && (n_rec <= room);
		s_tready    = !v_s1 || go;
		push.cnt    = go ? n_rec : 2'd0;
		push.first  = a_v ? rec_a : rec_b;
		push.second = rec_b;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			bpos_q   <= '0;
			acc_q    <= '0;
			length_q <= '0;
			ppos_q   <= '0;
			type_q   <= '0;
			clen_q   <= '0;
			ebc_q    <= '0;
		end else if (go) begin
			phase_q  <= phase_d;
			bpos_q   <= bpos_d;
			acc_q    <= acc_d;
			length_q <= length_d;
			ppos_q   <= ppos_d;
			type_q   <= type_d;
			clen_q   <= clen_d;
			ebc_q    <= ebc_d;
		end
	end

endmodule

// ----- sv/sdfp_outq.sv -----
// two-entry result queue, takes up to two records a cycle, presents the head
// depends on sdfp_pkg
module sdfp_outq import sdfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sdfp_push_t  push,
	output logic [1:0]  room,
	output logic        head_valid,
	input  logic        head_ready,
	output sdfp_rec_t   head
);

	logic [1:0] cnt_q;
	sdfp_rec_t  e0_q, e1_q;
	logic       pop;
	logic [1:0] cnt_pop;
	sdfp_rec_t  kept0;

	// occupancy after this cycle's pop
	always_comb begin
		pop        = (cnt_q != 2'd0) && head_ready;
		cnt_pop    = cnt_q - {1'b0, pop};
		room       = 2'd2 - cnt_pop;
		kept0      = pop ? e1_q : e0_q;
		head_valid = cnt_q != 2'd0;
		head       = e0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_pop + push.cnt;
		end
	end

	// shift down on pop, append behind what is kept
	always_ff @(posedge clk) begin
		if (cnt_pop == 2'd0) begin
			e0_q <= push.first;
			e1_q <= push.second;
		end else if (cnt_pop == 2'd1) begin
			e0_q <= kept0;
			e1_q <= push.first;
		end
	end

endmodule

// ----- sv/sdfp_checker.sv -----
// port-level checks on the discovery frame parser, bound to the top level
// depends on sdfp_pkg and snap_discovery_frame_parser
module sdfp_checker import sdfp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [IN_W-1:0]    s_tdata,
	input logic               s_tlast,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [TUSER_W-1:0] m_tuser,
	input logic               m_tlast
);

	// a stalled record stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled record changed");

	// every error record ends the frame
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_ERR) |-> m_tlast)
		else $error("error record without frame_done");

	// header records only carry known field numbers
	a_hdr_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_HDR) |-> (m_tdata[3:0] <= FLD_CHECKSUM))
		else $error("bad header field number");

	// entry records never show a length shorter than the entry header
	a_entry_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == KIND_ENTRY) || (m_tuser == KIND_VALUE))
			|-> (m_tdata[83:68] >= ENTRY_HDR_LEN))
		else $error("entry record with short length");

endmodule

bind snap_discovery_frame_parser sdfp_checker u_sdfp_checker (.*);

// ----- tb/tb.sv -----
// self-checking testbench for snap_discovery_frame_parser: byte driver, record monitor
// and a byte-by-byte prediction of the parser records; depends on sdfp_pkg and the parser rtl
// frames are mostly well formed with random content, plus truncated, short and noise frames
module tb;
	import sdfp_pkg::*;

	localparam int RANDOM_FILL  = -1;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_AFTER   = 600;
	localparam int HOLD_CYCLES  = 300;
	localparam int TARGET_BYTES = 2000;

	// one byte request waiting for the driver
	typedef struct {
		logic [7:0] data;
		logic       last;
		int         gap;
		bit         pause;
	} byte_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;     // [7:0] data_byte
	logic               s_tlast = 1'b0;   // frame_end
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;          // [3:0] field_id, [51:4] field_value,
	                                      // [67:52] entry_type, [83:68] entry_length
	logic [TUSER_W-1:0] m_tuser;          // [1:0] record_kind
	logic               m_tlast;          // frame_done

	snap_discovery_frame_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stimulus and bookkeeping
	byte_req_t   bytes_to_send[$];
	logic [7:0]  frame_buf[$];
	sdfp_rec_t   due_records[$];
	int          bytes_queued = 0;
	int          bytes_taken = 0;
	int          records_seen = 0;
	int          faults = 0;

	// parser state as predicted
	sdfp_phase_t phase = PH_HEADER;
	logic [15:0] hdr_pos = '0;
	logic [47:0] hdr_acc = '0;
	logic [15:0] len_field = '0;
	logic [15:0] pay_pos = '0;
	logic [15:0] ent_type = '0;
	logic [15:0] ent_len = '0;
	logic [15:0] ent_bytes = '0;

	function automatic void note_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endfunction

	function automatic void add_rec(input sdfp_kind_t kind, input logic [3:0] id,
			input logic [47:0] value, input logic [15:0] etype, input logic [15:0] elen,
			input logic done);
		sdfp_rec_t r;
		r.kind  = kind;
		r.id    = id;
		r.value = value;
		r.etype = etype;
		r.elen  = elen;
		r.done  = done;
		due_records = {due_records, r};
	endfunction

	function automatic void clear_parse();
		phase     = PH_HEADER;
		hdr_pos   = '0;
		hdr_acc   = '0;
		len_field = '0;
		pay_pos   = '0;
		ent_type  = '0;
		ent_len   = '0;
		ent_bytes = '0;
	endfunction

	// end of an entry: payload end is only checked here
	function automatic bit close_entry();
		ent_bytes = '0;
		if (pay_pos >= len_field - LEN_OVERHEAD) begin
			phase = PH_IGNORE;
			return 1'b1;
		end
		phase = PH_ENTRY_HDR;
		return 1'b0;
	endfunction

	// records caused by one accepted byte
	function automatic void parse_byte(input logic [7:0] b, input logic last);
		logic [15:0] p;
		logic [15:0] e;
		logic [3:0]  fid;
		bit          fin;
		fin = 1'b0;
		case (phase)
			PH_HEADER: begin
				p = hdr_pos;
				hdr_acc = {hdr_acc[39:0], b};
				if (hdr_pos != 16'hFFFF)
					hdr_pos = hdr_pos + 16'd1;
				// byte offsets at which each header field completes
				case (p)
					16'd5:   fid = FLD_DEST;
					16'd11:  fid = FLD_SOURCE;
					16'd13:  fid = FLD_LENGTH;
					16'd14:  fid = FLD_DSAP;
					16'd15:  fid = FLD_SSAP;
					16'd16:  fid = FLD_CONTROL;
					16'd19:  fid = FLD_OUI;
					16'd21:  fid = FLD_PROTO;
					16'd22:  fid = FLD_VERSION;
					16'd23:  fid = FLD_TTL;
					16'd25:  fid = FLD_CHECKSUM;
					default: fid = NO_FIELD;
				endcase
				if (fid != NO_FIELD) begin
					if (fid == FLD_LENGTH)
						len_field = hdr_acc[15:0];
					if (fid == FLD_CHECKSUM) begin
						if (len_field <= LEN_OVERHEAD) begin
							phase = PH_IGNORE;
							fin = 1'b1;
						end else begin
							phase = PH_ENTRY_HDR;
							pay_pos = '0;
							ent_bytes = '0;
						end
					end
					add_rec(KIND_HDR, fid, hdr_acc, 16'd0, 16'd0, fin);
					hdr_acc = '0;
				end
			end
			PH_ENTRY_HDR: begin
				e = ent_bytes;
				if (pay_pos != 16'hFFFF)
					pay_pos = pay_pos + 16'd1;
				case (e)
					16'd0:   ent_type = {8'h00, b};
					16'd1:   ent_type = {ent_type[7:0], b};
					16'd2:   ent_len = {8'h00, b};
					default: ent_len = {ent_len[7:0], b};
				endcase
				ent_bytes = e + 16'd1;
				if (e >= 16'd3) begin
					if (ent_len < ENTRY_HDR_LEN) begin
						phase = PH_IGNORE;
						add_rec(KIND_ERR, ERR_SHORT, 48'd0, ent_type, ent_len, 1'b1);
					end else if (ent_len == ENTRY_HDR_LEN) begin
						fin = close_entry();
						add_rec(KIND_ENTRY, 4'd0, 48'd0, ent_type, ent_len, fin);
					end else begin
						phase = PH_ENTRY_VAL;
						add_rec(KIND_ENTRY, 4'd0, 48'd0, ent_type, ent_len, 1'b0);
					end
				end
			end
			PH_ENTRY_VAL: begin
				if (pay_pos != 16'hFFFF)
					pay_pos = pay_pos + 16'd1;
				ent_bytes = ent_bytes + 16'd1;
				if (ent_bytes >= ent_len)
					fin = close_entry();
				add_rec(KIND_VALUE, 4'd0, {40'd0, b}, ent_type, ent_len, fin);
			end
			default: ;
		endcase
		// frame end before the payload is done gives a truncation error
		if (last) begin
			if (phase != PH_IGNORE)
				add_rec(KIND_ERR, ERR_TRUNC, 48'd0, ent_type, ent_len, 1'b1);
			clear_parse();
		end
	endfunction

	// frame building
	function automatic logic [7:0] pick_byte(input int fill);
		if (fill == RANDOM_FILL)
			return 8'($urandom_range(0, 255));
		return fill[7:0];
	endfunction

	function automatic void start_header(input logic [15:0] lf, input int fill);
		frame_buf.delete();
		for (int i = 0; i < 26; i++)
			frame_buf = {frame_buf, pick_byte(fill)};
		frame_buf[12] = lf[15:8];
		frame_buf[13] = lf[7:0];
	endfunction

	function automatic void set_length(input logic [15:0] lf);
		frame_buf[12] = lf[15:8];
		frame_buf[13] = lf[7:0];
	endfunction

	function automatic void add_entry(input logic [15:0] typ, input logic [15:0] len,
			input int nval, input int fill);
		frame_buf = {frame_buf, typ[15:8], typ[7:0], len[15:8], len[7:0]};
		for (int i = 0; i < nval; i++)
			frame_buf = {frame_buf, pick_byte(fill)};
	endfunction

	function automatic void add_junk(input int n);
		for (int i = 0; i < n; i++)
			frame_buf = {frame_buf, pick_byte(RANDOM_FILL)};
	endfunction

	// queue the first count bytes of the frame, the last of them marked
	function automatic void send_frame(input int count, input bit wait_idle);
		byte_req_t r;
		bit quiet;
		quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			r.data  = frame_buf[i];
			r.last  = (i == count - 1);
			r.gap   = quiet ? 0 : $urandom_range(0, 15);
			r.pause = wait_idle && (i == 0);
			bytes_to_send = {bytes_to_send, r};
			bytes_queued++;
		end
	endfunction

	function automatic void build_random_frame();
		int roll;
		int nent;
		int len;
		int pay;
		logic [15:0] lf;
		roll = $urandom_range(0, 99);
		nent = $urandom_range(0, 4);
		pay = 0;
		start_header(16'd0, RANDOM_FILL);
		if (roll >= 92) begin
			// noise, often ending inside the header
			frame_buf.delete();
			add_junk($urandom_range(1, 60));
			send_frame(frame_buf.size(), $urandom_range(0, 9) == 0);
			return;
		end
		if (roll >= 85) begin
			// no payload
			set_length(16'($urandom_range(0, 12)));
			add_junk($urandom_range(0, 4));
			send_frame(frame_buf.size(), $urandom_range(0, 9) == 0);
			return;
		end
		for (int i = 0; i < nent; i++) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 40) : $urandom_range(4, 10);
			add_entry(16'($urandom_range(0, 65535)), 16'(len), len - 4, RANDOM_FILL);
			pay += len;
		end
		lf = 16'(12 + pay);
		if (roll < 60) begin
			// well formed, sometimes with a length field that disagrees
			if ($urandom_range(0, 9) == 0)
				lf = 16'(12 + $urandom_range(0, pay + 4));
			set_length(lf);
			add_junk($urandom_range(0, 6));
			send_frame(frame_buf.size(), $urandom_range(0, 9) == 0);
		end else if (roll < 75) begin
			// frame ends early, inside the payload or the header
			if ($urandom_range(0, 1) == 0) begin
				len = $urandom_range(4, 65535);
				add_entry(16'($urandom_range(0, 65535)), 16'(len),
					$urandom_range(0, 8), RANDOM_FILL);
				set_length(16'(12 + pay + len));
				send_frame(frame_buf.size(), $urandom_range(0, 9) == 0);
			end else begin
				set_length(lf);
				send_frame($urandom_range(1, frame_buf.size()), $urandom_range(0, 9) == 0);
			end
		end else begin
			// short entry after the good ones
			add_entry(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3)), 0,
				RANDOM_FILL);
			set_length(16'(12 + pay + $urandom_range(4, 20)));
			add_junk($urandom_range(0, 5));
			send_frame(frame_buf.size(), $urandom_range(0, 9) == 0);
		end
	endfunction

	// driver: one byte request at a time, gap drawn per byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (bytes_to_send.size() == 0 ||
						(bytes_to_send[0].pause && due_records.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else if (bytes_to_send[0].gap != 0) begin
					bytes_to_send[0].gap = bytes_to_send[0].gap - 1;
					s_tvalid <= 1'b0;
				end else begin
					s_tdata  <= bytes_to_send[0].data;
					s_tlast  <= bytes_to_send[0].last;
					s_tvalid <= 1'b1;
					void'(bytes_to_send.pop_front());
				end
			end
		end
	end

	// long receiver hold-off, once, while the sender keeps offering
	logic rx_hold = 1'b0;
	bit   hold_used = 1'b0;
	int   hold_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_used && bytes_taken >= HOLD_AFTER) begin
				hold_used <= 1'b1;
				rx_hold   <= 1'b1;
				hold_left <= HOLD_CYCLES;
			end else if (rx_hold) begin
				if (hold_left <= 1)
					rx_hold <= 1'b0;
				hold_left <= hold_left - 1;
			end
		end
	end

	// monitor: compare each record with the oldest one due
	int          rx_wait = 0;
	int          cycle_count = 0;
	sdfp_rec_t   seen;
	sdfp_rec_t   want;

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (m_tvalid && m_tready) begin
				records_seen++;
				seen.kind  = sdfp_kind_t'(m_tuser);
				seen.id    = m_tdata[3:0];
				seen.value = m_tdata[51:4];
				seen.etype = m_tdata[67:52];
				seen.elen  = m_tdata[83:68];
				seen.done  = m_tlast;
				if (due_records.size() == 0) begin
					note_fault($sformatf("record %0d arrived with nothing due: kind %0d id %0d",
						records_seen, seen.kind, seen.id));
				end else begin
					want = due_records.pop_front();
					if (seen.kind !== want.kind || seen.id !== want.id ||
							seen.value !== want.value || seen.etype !== want.etype ||
							seen.elen !== want.elen || seen.done !== want.done)
						note_fault($sformatf({"mismatch on record %0d: expected kind %0d id %0d ",
							"value %h type %h len %h done %b, got kind %0d id %0d value %h ",
							"type %h len %h done %b"}, records_seen,
							want.kind, want.id, want.value, want.etype, want.elen, want.done,
							seen.kind, seen.id, seen.value, seen.etype, seen.elen, seen.done));
				end
				// stretches of back-to-back acceptance alternate with random stalls
				rx_wait = cycle_count[8] ? 0 : $urandom_range(0, 15);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= (rx_wait == 0) && !rx_hold;
		end
	end

	// watchdog on cycles with no request taken on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// directed frames, random frames, then drain and report
	initial begin
		clear_parse();

		// all-zero header, empty payload
		start_header(16'h0000, 8'h00);
		send_frame(frame_buf.size(), 1'b1);
		// all-ones header ending on the checksum: checksum and truncation together
		start_header(16'hFFFF, 8'hFF);
		send_frame(frame_buf.size(), 1'b1);
		// bare entry, one and two value bytes, then padding
		start_header(16'd27, RANDOM_FILL);
		add_entry(16'hFFFF, 16'd4, 0, RANDOM_FILL);
		add_entry(16'h0000, 16'd5, 1, 8'hFF);
		add_entry(16'h1234, 16'd6, 2, 8'h00);
		add_junk(3);
		send_frame(frame_buf.size(), 1'b1);
		// short entries of length three and zero
		start_header(16'd16, RANDOM_FILL);
		add_entry(16'hABCD, 16'd3, 0, RANDOM_FILL);
		add_junk(4);
		send_frame(frame_buf.size(), 1'b1);
		start_header(16'd40, RANDOM_FILL);
		add_entry(16'h0001, 16'd0, 0, RANDOM_FILL);
		send_frame(frame_buf.size(), 1'b1);
		// frame of a single byte
		start_header(16'd0, RANDOM_FILL);
		send_frame(1, 1'b1);
		// entry running past the payload end, read to its own end
		start_header(16'd15, RANDOM_FILL);
		add_entry(16'h00A5, 16'd7, 3, RANDOM_FILL);
		add_junk(2);
		send_frame(frame_buf.size(), 1'b1);
		// frame ending inside the value bytes
		start_header(16'd32, RANDOM_FILL);
		add_entry(16'h5A00, 16'd20, 16, RANDOM_FILL);
		send_frame(26 + 4 + 5, 1'b1);

		while (bytes_queued < TARGET_BYTES)
			build_random_frame();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_to_send.size() != 0 || s_tvalid || due_records.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (due_records.size() != 0)
			note_fault($sformatf("%0d records still due at the end", due_records.size()));
		if (faults == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/sdfp_pkg.sv
sv/sdfp_parse.sv
sv/sdfp_outq.sv
sv/snap_discovery_frame_parser.sv
sv/sdfp_checker.sv
tb/tb.sv
